FILE: rtl/core/tdf_pkg.sv
package tdf_pkg;

    // width of the value that is factored
    localparam int NUM_W      = 31;
    // field widths of the ports
    localparam int IN_W       = 31;
    localparam int PRIME_W    = 31;
    localparam int EXP_W      = 5;
    // trial divisor never passes floor(sqrt(2^NUM_W - 1)) + 1
    localparam int D_W        = (NUM_W + 1) / 2 + 1;
    // step counter of the divider
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    // distinct primes reported per input
    localparam int MAX_RESULTS = 9;
    localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_REC,
        ST_FIN,
        ST_INV
    } t_state;

    typedef enum logic [1:0] {
        OUT_PEND,
        OUT_REM,
        OUT_INV
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     take_quot;
        logic     rec;
        logic     next_d;
        logic     clr_pend;
        logic     out_load;
        logic     out_last;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic r_zero;
        logic stop;
        logic e_nz;
        logic pend_v;
        logic rem_gt1;
        logic rem_lt2;
        logic cnt_max;
        logic out_free;
    } t_status;

    function automatic logic [EXP_W-1:0] sat_add(input logic [EXP_W-1:0] a,
                                                 input logic [EXP_W-1:0] b);
        logic [EXP_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[EXP_W]) begin
            return EXP_MAX;
        end
        return sum[EXP_W-1:0];
    endfunction

endpackage

FILE: rtl/core/tdf_div.sv
module tdf_div
    import tdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [D_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [D_W-1:0]   o_rem
);

    // restoring divider, one quotient bit per cycle
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0]     r_quo, n_quo;
    logic [D_W-1:0]       r_rem, n_rem;
    logic [D_W-1:0]       r_dvs, n_dvs;

    logic [D_W:0] trial;
    logic         ge;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(NUM_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_rem = ge ? D_W'(trial - {1'b0, r_dvs}) : trial[D_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

FILE: rtl/core/tdf_dp.sv
module tdf_dp
    import tdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [IN_W-1:0]    i_number,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [PRIME_W-1:0] o_prime_factor,
    output logic [EXP_W-1:0]   o_exponent,
    output logic [EXP_W-1:0]   o_factor_count,
    output logic               o_last,
    output logic               o_invalid
);

    logic [NUM_W-1:0]     r_rem;
    logic [D_W-1:0]       r_d;
    logic [EXP_W-1:0]     r_e;
    logic [EXP_W-1:0]     r_total;
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 r_first;

    // prime found but not yet sent, held until we know if it is the last
    logic                 r_pend_v;
    logic [D_W-1:0]       r_pend_p;
    logic [EXP_W-1:0]     r_pend_e;
    logic [EXP_W-1:0]     r_pend_t;

    logic                 r_o_valid;
    logic [PRIME_W-1:0]   r_o_prime;
    logic [EXP_W-1:0]     r_o_exp;
    logic [EXP_W-1:0]     r_o_cnt;
    logic                 r_o_last;
    logic                 r_o_inv;

    logic                 div_done;
    logic [NUM_W-1:0]     quot;
    logic [D_W-1:0]       drem;
    logic                 out_free;
    logic [EXP_W-1:0]     e_inc;
    logic [EXP_W-1:0]     total_rec;

    tdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rem),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (drem)
    );

    always_comb begin
        out_free  = !r_o_valid || !i_stall;
        e_inc     = (r_e == EXP_MAX) ? r_e : r_e + 1'b1;
        total_rec = sat_add(r_total, r_e);

        o_status.div_done = div_done;
        o_status.r_zero   = (drem == '0);
        o_status.cnt_max  = (r_cnt == RES_CNT_W'(MAX_RESULTS));
        o_status.stop     = r_first && ((NUM_W'(r_d) > quot) || o_status.cnt_max);
        o_status.e_nz     = (r_e != '0);
        o_status.pend_v   = r_pend_v;
        o_status.rem_gt1  = (r_rem > NUM_W'(1));
        o_status.rem_lt2  = (r_rem < NUM_W'(2));
        o_status.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= NUM_W'(i_number);
            r_d     <= D_W'(2);
            r_e     <= '0;
            r_total <= '0;
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.take_quot) begin
            r_rem   <= quot;
            r_e     <= e_inc;
            r_first <= 1'b0;
        end else if (i_cmd.rec) begin
            r_pend_p <= r_d;
            r_pend_e <= r_e;
            r_pend_t <= total_rec;
            r_total  <= total_rec;
            r_cnt    <= r_cnt + 1'b1;
            r_e      <= '0;
            r_d      <= r_d + 1'b1;
            r_first  <= 1'b1;
        end else if (i_cmd.next_d) begin
            r_d     <= r_d + 1'b1;
            r_first <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.load || i_cmd.clr_pend) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.rec) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_last <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OUT_PEND: begin
                    r_o_prime <= PRIME_W'(r_pend_p);
                    r_o_exp   <= r_pend_e;
                    r_o_cnt   <= r_pend_t;
                    r_o_inv   <= 1'b0;
                end
                OUT_REM: begin
                    r_o_prime <= PRIME_W'(r_rem);
                    r_o_exp   <= EXP_W'(1);
                    r_o_cnt   <= sat_add(r_total, EXP_W'(1));
                    r_o_inv   <= 1'b0;
                end
                default: begin
                    r_o_prime <= '0;
                    r_o_exp   <= '0;
                    r_o_cnt   <= '0;
                    r_o_inv   <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_prime_factor = r_o_prime;
    assign o_exponent     = r_o_exp;
    assign o_factor_count = r_o_cnt;
    assign o_last         = r_o_last;
    assign o_invalid      = r_o_inv;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten while stalled");

    a_pend_sent_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && i_cmd.out_sel == OUT_PEND) |-> r_pend_v)
        else $error("pending prime sent while empty");

endmodule

FILE: rtl/core/tdf_ctrl.sv
module tdf_ctrl
    import tdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.rem_lt2 ? ST_INV : ST_DIV_WAIT;
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.stop) begin
                        n_state = ST_FIN;
                    end else if (i_status.r_zero) begin
                        n_state = ST_DIV_GO;
                    end else if (i_status.e_nz) begin
                        n_state = ST_REC;
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_REC: begin
                if (!i_status.pend_v || i_status.out_free) begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    if (!(i_status.rem_gt1 && !i_status.cnt_max && i_status.pend_v)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_INV: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = OUT_PEND;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_valid;
            end
            ST_CHECK: begin
                o_cmd.div_start = !i_status.rem_lt2;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done && !i_status.stop) begin
                    if (i_status.r_zero) begin
                        o_cmd.take_quot = 1'b1;
                    end else if (!i_status.e_nz) begin
                        o_cmd.next_d = 1'b1;
                    end
                end
            end
            ST_REC: begin
                if (!i_status.pend_v || i_status.out_free) begin
                    o_cmd.rec      = 1'b1;
                    o_cmd.out_load = i_status.pend_v;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.rem_gt1 && !i_status.cnt_max) begin
                        if (i_status.pend_v) begin
                            o_cmd.clr_pend = 1'b1;
                        end else begin
                            o_cmd.out_sel  = OUT_REM;
                            o_cmd.out_last = 1'b1;
                        end
                    end else begin
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            ST_INV: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_INV;
                    o_cmd.out_last = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/core/trial_division_factorizer.sv
// trial-division prime factorizer
//
// input channel: i_number with i_valid; a transfer happens on a rising edge
// with i_valid high and o_stall low. o_stall is high from the cycle after a
// transfer until the last result of that number has been loaded into the
// output register, so one number is worked on at a time.
// output channel: one transfer per distinct prime factor, in rising order,
// on o_valid high and i_stall low. o_last marks the final result. a number
// below two gives one result with o_invalid set and all counts zero.
// every trial division, for a new divisor or a repeat by a prime that just
// divided, runs on the shared restoring divider: start, one quotient bit per
// cycle, then the sequencer acts on the result; each prime found adds a
// recording step. worst case is a prime near 2^31: about 46340 divisors.
// a held output (i_stall high) lets the search go on; it only waits when the
// next result is ready while the output register is still full.
// reset (synchronous, active low) clears the state machine, divider busy/done,
// output valid and the pending-result flag; nothing is carried between numbers.
module trial_division_factorizer
    import tdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // number to factor
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [IN_W-1:0]    i_number,
    // factor results
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PRIME_W-1:0] o_prime_factor,
    output logic [EXP_W-1:0]   o_exponent,
    output logic [EXP_W-1:0]   o_factor_count,
    output logic               o_last,
    output logic               o_invalid
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    tdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // remainder, divisor, counts, pending prime, divider and output register
    tdf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_number       (i_number),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_prime_factor (o_prime_factor),
        .o_exponent     (o_exponent),
        .o_factor_count (o_factor_count),
        .o_last         (o_last),
        .o_invalid      (o_invalid)
    );

endmodule
